[src/lsrc_pkg.sv]
`default_nettype none

package lsrc_pkg;

  // Field widths fixed by the interface.
  localparam int MinuteW  = 11;
  localparam int SecondW  = 6;
  localparam int PctW     = 7;
  localparam int DacW     = 14;
  localparam int EnW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 14;

  // The DAC code saturates at 2^DacBits - 1.
  localparam int DacBits = 14;
  localparam int DacTop  = (1 << DacBits) - 1;

  localparam int PctFull = 100;

  // Reset values of the configuration registers.
  localparam int RstOnMinute    = 360;
  localparam int RstOffMinute   = 1320;
  localparam int RstRiseEnd     = 390;
  localparam int RstFallStart   = 1260;
  localparam int RstRampEnables = 0;
  localparam int RstMaxPercent  = 80;
  localparam int RstVoltLow     = 0;
  localparam int RstVoltHigh    = 1000;

  // Hour = minute / 60, done as a multiply by a scaled reciprocal. The error
  // stays below one part in the last place for all 11-bit minute values.
  localparam int HourW      = 6;
  localparam int HourRecip  = 2185;
  localparam int HourShift  = 17;
  localparam int HourProdW  = MinuteW + 12;

  // Ramp divider: quotient below 128, numerator and divisor below 2^17.
  localparam int QuotW    = 7;
  localparam int RampW    = 17;
  localparam int DvdW     = 24;
  localparam int DvsW     = RampW + QuotW - 1;
  // Signed width of minute differences times 60 plus seconds.
  localparam int TimeW    = 19;

  // Percent-to-code map: |span * pct| below 2^21, divided by 100 through a
  // reciprocal that overshoots by at most one, then corrected.
  localparam int ProdW      = 22;
  localparam int MagW       = 21;
  localparam int Recip100   = 5243;
  localparam int RecipShift = 19;
  localparam int RecipProdW = 35;
  localparam int QuoW       = 15;
  localparam int VoltW      = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ON_MINUTE,
    CFG_OFF_MINUTE,
    CFG_RISE_END_MINUTE,
    CFG_FALL_START_MINUTE,
    CFG_RAMP_ENABLES,
    CFG_MAX_PERCENT,
    CFG_VOLT_LOW,
    CFG_VOLT_HIGH
  } cfg_index_t;

  typedef enum logic [1:0] {
    LS_OFF  = 2'd0,
    LS_ON   = 2'd1,
    LS_RISE = 2'd2,
    LS_FALL = 2'd3
  } lamp_state_t;

  typedef enum logic [1:0] {
    PSEL_ZERO,
    PSEL_MAX,
    PSEL_DIV
  } pct_sel_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_HOUR,
    CS_EVAL,
    CS_DIV,
    CS_MUL,
    CS_RECIP,
    CS_FIX,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [MinuteW-1:0] minute_of_day;
    logic [SecondW-1:0] second;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      lamp_state;
    logic [PctW-1:0] light_percent;
    logic [DacW-1:0] dac_value;
    logic            dac_write;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic hour_en;
    logic eval_en;
    logic div_en;
    logic mul_en;
    logic recip_en;
    logic fix_en;
    logic commit;
  } dp_cmd_t;

  function automatic logic [HourW-1:0] hour_of(input logic [MinuteW-1:0] minute);
    logic [HourProdW-1:0] prod;
    prod = HourProdW'(minute) * HourProdW'(HourRecip);
    return prod[HourShift +: HourW];
  endfunction

endpackage

`default_nettype wire

[src/light_schedule_ramp_controller_unit.sv]
// Light schedule ramp controller.
//
// Each input transfer on in_* carries one tick: the minute of day and the
// second within it. The block steps a four-state schedule (off, on, sunrise,
// sunset), works out the light level in percent and maps it onto a DAC code
// between volt_low and volt_high (zero when off). Every tick gives exactly one
// result transfer on out_*, with dac_write set when the code or the state
// differs from the last written one (the first tick after reset always writes).
// The schedule registers are written through cfg_we, cfg_index and cfg_wdata;
// write them only while no tick is in flight, which the block does not enforce.
// One tick is handled at a time: no new input transfer is taken until the
// result of the last one has been committed to the output register; the
// 7-step serial ramp divider is the longest part of the work on each tick.
// A finished result waits in the output register while out_stall is high;
// the next tick completes only after that register has been freed.
// Synchronous reset puts the schedule in the off state, restores the
// register defaults and empties the output register.
`default_nettype none

module light_schedule_ramp_controller_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lsrc_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lsrc_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [lsrc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lsrc_pkg::CfgDataW-1:0] cfg_wdata
);
  import lsrc_pkg::*;

  // Command bundle from the sequencer to the datapath.
  dp_cmd_t cmd;

  // The sequencer walks through capture, hour lookup, schedule evaluation,
  // seven divide steps, the two multiplies of the percent-to-code map, the
  // reciprocal correction and the final commit into the output register.
  lsrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the configuration registers, the schedule state, the
  // shared divider and the output register.
  lsrc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/lsrc_ctrl.sv]
`default_nettype none

module lsrc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lsrc_pkg::dp_cmd_t      cmd
);
  import lsrc_pkg::*;

  localparam int StepW = $clog2(QuotW);

  ctrl_state_t        state_r, state_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = CS_HOUR;
        end
      end
      CS_HOUR: begin
        cmd.hour_en = 1'b1;
        state_nxt   = CS_EVAL;
      end
      CS_EVAL: begin
        cmd.eval_en = 1'b1;
        step_nxt    = StepW'(QuotW - 1);
        state_nxt   = CS_DIV;
      end
      CS_DIV: begin
        cmd.div_en = 1'b1;
        if (step_r == '0) begin
          state_nxt = CS_MUL;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      CS_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = CS_RECIP;
      end
      CS_RECIP: begin
        cmd.recip_en = 1'b1;
        state_nxt    = CS_FIX;
      end
      CS_FIX: begin
        cmd.fix_en = 1'b1;
        state_nxt  = CS_DONE;
      end
      CS_DONE: begin
        // The result register must be free before the new result goes in.
        if (!(out_valid_r && out_stall)) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != CS_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/lsrc_datapath.sv]
`default_nettype none

module lsrc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lsrc_pkg::dp_cmd_t             cmd,
  input  wire lsrc_pkg::in_item_t            in_data,
  input  wire logic                          cfg_we,
  input  wire logic [lsrc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lsrc_pkg::CfgDataW-1:0] cfg_wdata,
  output lsrc_pkg::out_item_t                out_data
);
  import lsrc_pkg::*;

  // Configuration registers.
  logic [MinuteW-1:0] on_min_r, off_min_r, rise_end_r, fall_start_r;
  logic [EnW-1:0]     ramp_en_r;
  logic [PctW-1:0]    max_pct_r;
  logic [DacW-1:0]    volt_low_r, volt_high_r;

  // Item and schedule state.
  logic [MinuteW-1:0] now_r;
  logic [SecondW-1:0] sec_r;
  logic [HourW-1:0]   onh_r, offh_r;
  lamp_state_t        mode_r, mode_nxt;
  pct_sel_t           sel_r, sel_nxt;
  logic               map_r, map_nxt;

  // Divider.
  logic [DvdW-1:0]    rem_r;
  logic [DvsW-1:0]    dvs_r;
  logic [QuotW-1:0]   q_r;
  logic [DvdW-1:0]    trial;

  // Map pipeline.
  logic [PctW-1:0]         pct_r, pct_c, eff_max;
  logic signed [ProdW-1:0] prod_r, span_w, pct_w;
  logic signed [DacW:0]    span;
  logic                    neg_r;
  logic [MagW-1:0]         mag_r, mag_c;
  logic [RecipProdW-1:0]   recip_prod;
  logic [QuoW-1:0]         quo_r, quo_fix;
  logic [ProdW-1:0]        back;
  logic signed [VoltW-1:0] volt_c, lo_x, quo_x;
  logic [DacW-1:0]         code_r, code_c;

  // Write tracking.
  logic [DacW-1:0]    last_val_r;
  lamp_state_t        last_st_r;
  logic               written_r;
  logic               wr_c;
  out_item_t          out_r;

  // Schedule evaluation.
  logic                    in_on;
  logic signed [TimeW-1:0] now_x, sec_x, on_x, off_x, re_x, fs_x;
  logic signed [TimeW-1:0] el_rise, tot_rise, el_fall, tot_fall, el_fc, rem_f;
  logic [RampW-1:0]        num_c, den_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_min_r     <= MinuteW'(RstOnMinute);
      off_min_r    <= MinuteW'(RstOffMinute);
      rise_end_r   <= MinuteW'(RstRiseEnd);
      fall_start_r <= MinuteW'(RstFallStart);
      ramp_en_r    <= EnW'(RstRampEnables);
      max_pct_r    <= PctW'(RstMaxPercent);
      volt_low_r   <= DacW'(RstVoltLow);
      volt_high_r  <= DacW'(RstVoltHigh);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_MINUTE:         on_min_r     <= cfg_wdata[MinuteW-1:0];
        CFG_OFF_MINUTE:        off_min_r    <= cfg_wdata[MinuteW-1:0];
        CFG_RISE_END_MINUTE:   rise_end_r   <= cfg_wdata[MinuteW-1:0];
        CFG_FALL_START_MINUTE: fall_start_r <= cfg_wdata[MinuteW-1:0];
        CFG_RAMP_ENABLES:      ramp_en_r    <= cfg_wdata[EnW-1:0];
        CFG_MAX_PERCENT:       max_pct_r    <= cfg_wdata[PctW-1:0];
        CFG_VOLT_LOW:          volt_low_r   <= cfg_wdata[DacW-1:0];
        CFG_VOLT_HIGH:         volt_high_r  <= cfg_wdata[DacW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Compare hours for midnight wrap, then minutes; equal hours stay off.
  always_comb begin
    if (onh_r < offh_r) begin
      in_on = (now_r >= on_min_r) && (now_r < off_min_r);
    end else if (onh_r > offh_r) begin
      in_on = (now_r >= on_min_r) || (now_r < off_min_r);
    end else begin
      in_on = 1'b0;
    end
  end

  always_comb begin
    case (mode_r)
      LS_OFF: begin
        if (in_on) begin
          mode_nxt = ramp_en_r[0] ? LS_RISE : LS_ON;
        end else begin
          mode_nxt = LS_OFF;
        end
      end
      LS_ON: begin
        if (!in_on) begin
          mode_nxt = (ramp_en_r[1] && (now_r >= fall_start_r) && (now_r < off_min_r))
                     ? LS_FALL : LS_OFF;
        end else begin
          mode_nxt = LS_ON;
        end
      end
      LS_RISE: begin
        mode_nxt = (!ramp_en_r[0] || (now_r >= rise_end_r)) ? LS_ON : LS_RISE;
      end
      LS_FALL: begin
        mode_nxt = (!ramp_en_r[1] || (now_r >= off_min_r) || (now_r < fall_start_r))
                   ? LS_OFF : LS_FALL;
      end
      default: begin
        mode_nxt = LS_OFF;
      end
    endcase
  end

  assign now_x = $signed({8'd0, now_r});
  assign sec_x = $signed({13'd0, sec_r});
  assign on_x  = $signed({8'd0, on_min_r});
  assign off_x = $signed({8'd0, off_min_r});
  assign re_x  = $signed({8'd0, rise_end_r});
  assign fs_x  = $signed({8'd0, fall_start_r});

  assign el_rise  = (now_x - on_x) * 19'sd60 + sec_x;
  assign tot_rise = (re_x - on_x) * 19'sd60;
  assign el_fall  = (now_x - fs_x) * 19'sd60 + sec_x;
  assign tot_fall = (off_x - fs_x) * 19'sd60;
  // A sunset with no elapsed time still counts one second.
  assign el_fc    = (el_fall <= 19'sd0) ? 19'sd1 : el_fall;
  assign rem_f    = tot_fall - el_fc;

  // Pick the percent source. The divide is only used when the numerator is
  // below the divisor, so the quotient is always below 100.
  always_comb begin
    sel_nxt = PSEL_ZERO;
    map_nxt = 1'b0;
    num_c   = '0;
    den_c   = '0;
    case (mode_nxt)
      LS_ON: begin
        sel_nxt = PSEL_MAX;
        map_nxt = 1'b1;
      end
      LS_RISE: begin
        if (ramp_en_r[0]) begin
          map_nxt = 1'b1;
          if (tot_rise <= 19'sd0) begin
            sel_nxt = PSEL_MAX;
          end else if (el_rise <= 19'sd0) begin
            sel_nxt = PSEL_ZERO;
          end else if (el_rise >= tot_rise) begin
            sel_nxt = PSEL_MAX;
          end else begin
            sel_nxt = PSEL_DIV;
            num_c   = el_rise[RampW-1:0];
            den_c   = tot_rise[RampW-1:0];
          end
        end
      end
      LS_FALL: begin
        if (ramp_en_r[1]) begin
          map_nxt = 1'b1;
          if (tot_fall <= 19'sd0) begin
            sel_nxt = PSEL_MAX;
          end else if ((el_fall <= 19'sd0) && (now_r < fall_start_r)) begin
            sel_nxt = PSEL_MAX;
          end else if (rem_f <= 19'sd0) begin
            sel_nxt = PSEL_ZERO;
          end else begin
            sel_nxt = PSEL_DIV;
            num_c   = rem_f[RampW-1:0];
            den_c   = tot_fall[RampW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign trial = DvdW'(dvs_r);

  assign eff_max = (max_pct_r > PctW'(PctFull)) ? PctW'(PctFull) : max_pct_r;

  always_comb begin
    case (sel_r)
      PSEL_ZERO: pct_c = '0;
      PSEL_MAX:  pct_c = eff_max;
      PSEL_DIV:  pct_c = (q_r < eff_max) ? q_r : eff_max;
      default:   pct_c = '0;
    endcase
  end

  assign span   = $signed({1'b0, volt_high_r}) - $signed({1'b0, volt_low_r});
  assign span_w = ProdW'(span);
  assign pct_w  = $signed({15'd0, pct_c});

  assign mag_c      = prod_r[ProdW-1] ? MagW'(-prod_r) : MagW'(prod_r);
  assign recip_prod = RecipProdW'(mag_c) * RecipProdW'(Recip100);

  assign back    = ProdW'(quo_r) * ProdW'(PctFull);
  assign quo_fix = (back > ProdW'(mag_r)) ? quo_r - 1'b1 : quo_r;
  assign lo_x    = $signed({3'd0, volt_low_r});
  assign quo_x   = $signed({2'd0, quo_fix});
  assign volt_c  = neg_r ? (lo_x - quo_x) : (lo_x + quo_x);

  always_comb begin
    if (!map_r || (volt_c < 17'sd0)) begin
      code_c = '0;
    end else if (volt_c > VoltW'(DacTop)) begin
      code_c = DacW'(DacTop);
    end else begin
      code_c = volt_c[DacW-1:0];
    end
  end

  assign wr_c = !written_r || (code_r != last_val_r) || (mode_r != last_st_r);

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r <= in_data.minute_of_day;
      sec_r <= in_data.second;
    end
    if (cmd.hour_en) begin
      onh_r  <= hour_of(on_min_r);
      offh_r <= hour_of(off_min_r);
    end
    if (cmd.eval_en) begin
      sel_r <= sel_nxt;
      map_r <= map_nxt;
      rem_r <= DvdW'(num_c) * DvdW'(PctFull);
      dvs_r <= {den_c, {(QuotW-1){1'b0}}};
      q_r   <= '0;
    end
    if (cmd.div_en) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        q_r   <= {q_r[QuotW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QuotW-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.mul_en) begin
      pct_r  <= pct_c;
      prod_r <= span_w * pct_w;
    end
    if (cmd.recip_en) begin
      neg_r <= prod_r[ProdW-1];
      mag_r <= mag_c;
      quo_r <= recip_prod[RecipShift +: QuoW];
    end
    if (cmd.fix_en) begin
      code_r <= code_c;
    end
    if (cmd.commit) begin
      out_r.lamp_state    <= mode_r;
      out_r.light_percent <= pct_r;
      out_r.dac_value     <= code_r;
      out_r.dac_write     <= wr_c;
    end
  end

  // Schedule state and the last written DAC transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= LS_OFF;
      last_val_r <= '0;
      last_st_r  <= LS_OFF;
      written_r  <= 1'b0;
    end else begin
      if (cmd.eval_en) begin
        mode_r <= mode_nxt;
      end
      if (cmd.commit && wr_c) begin
        last_val_r <= code_r;
        last_st_r  <= mode_r;
        written_r  <= 1'b1;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[src/lsrc_checker.sv]
`default_nettype none

module lsrc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lsrc_pkg::out_item_t out_data
);
  import lsrc_pkg::*;

  // Only one tick is in flight: a transfer closes the input at once.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a tick is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.lamp_state == LS_OFF) |->
      (out_data.light_percent == '0) && (out_data.dac_value == '0))
    else $error("off state with nonzero light");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.light_percent <= PctW'(PctFull)))
    else $error("light percent above full scale");

endmodule

bind light_schedule_ramp_controller_unit lsrc_checker u_lsrc_checker (.*);

`default_nettype wire
